### hw/rtl/cde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cde_pkg
// Shared widths, constants, stage control and calendar tables for the
// civil date to epoch converter.
// ----------------------------------------------------------------------------
package cde_pkg;

  // Field widths of the date and result transfers.
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int EPOCH_W  = 32;

  // Internal widths.
  localparam int DAYS_W = 21;  // day count since 1970-01-01 (valid dates < 2^20)
  localparam int SOD_W  = 17;  // seconds of the day, below 86400
  localparam int SECS_W = 38;  // full second count before the range check
  localparam int MOFF_W = 9;   // day offset of a month within a March-based year
  localparam int QY_W   = 10;  // a year divided by four
  localparam int MULQ_W = 23;  // QY_W times the reciprocal constant

  // Calendar constants.
  localparam int YEAR_MIN      = 1970;
  localparam int EPOCH_SHIFT   = 719468;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int DAYS_PER_YEAR = 365;

  // Division by 25 of a 10-bit value: (x * 5243) >> 17 is exact below 1024.
  localparam int DIV25_MUL   = 5243;
  localparam int DIV25_SHIFT = 17;
  localparam int DIV25_MUL_W = 13;

  // Load enables of the two front stages, driven by the top level.
  typedef struct packed {
    logic load1;
    logic load2;
  } cde_ctrl_t;

  // Days from March 1 to the first day of the given month (1 to 12).
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [MOFF_W-1:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of the given month; zero for a month number that means nothing.
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/cde_days.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cde_days
// Front two pipeline stages: field checks, day count since 1970-01-01 and
// seconds of the day.
// ----------------------------------------------------------------------------
module cde_days (
  input  logic                           clk,
  input  cde_pkg::cde_ctrl_t             ctrl,
  input  logic [cde_pkg::YEAR_W-1:0]     year,
  input  logic [cde_pkg::MONTH_W-1:0]    month,
  input  logic [cde_pkg::DAY_W-1:0]      day,
  input  logic [cde_pkg::HOUR_W-1:0]     hour,
  input  logic [cde_pkg::MINUTE_W-1:0]   minute,
  input  logic [cde_pkg::SECOND_W-1:0]   second,
  output logic [cde_pkg::DAYS_W-1:0]     days,
  output logic [cde_pkg::SOD_W-1:0]      sod,
  output logic                           ok
);
  import cde_pkg::*;

  localparam int SUM_W = DAYS_W + 1;

  // Stage 1 registers.
  logic [YEAR_W-1:0]  yy1;
  logic [MULQ_W-1:0]  amul1;
  logic [QY_W-1:0]    c1;
  logic [MULQ_W-1:0]  cmul1;
  logic [1:0]         ylow1;
  logic [MOFF_W-1:0]  moff1;
  logic [MONTH_W-1:0] month1;
  logic [DAY_W-1:0]   day1;
  logic [SOD_W-1:0]   sod1;
  logic               fok1;

  // Stage 1 logic.
  logic [YEAR_W-1:0] yy_c;
  logic [SOD_W-1:0]  sod_c;
  logic              fok_c;

  // The year starts in March, so January and February count to the year before.
  always_comb begin
    yy_c  = (month <= MONTH_W'(2)) ? year - YEAR_W'(1) : year;
    sod_c = SOD_W'(hour) * SOD_W'(SECS_PER_HOUR) + SOD_W'(minute) * SOD_W'(SECS_PER_MIN)
          + SOD_W'(second);
    fok_c = (year >= YEAR_W'(YEAR_MIN)) && (month >= MONTH_W'(1)) &&
            (month <= MONTH_W'(12)) && (hour <= HOUR_W'(23)) &&
            (minute <= MINUTE_W'(59)) && (second <= SECOND_W'(59));
  end

  // Stage 1 register: reciprocal products for the divisions by 25, with the fields and checks.
  always_ff @(posedge clk) begin
    if (ctrl.load1) begin
      yy1    <= yy_c;
      amul1  <= MULQ_W'(yy_c[YEAR_W-1:2]) * MULQ_W'(DIV25_MUL);
      c1     <= year[YEAR_W-1:2];
      cmul1  <= MULQ_W'(year[YEAR_W-1:2]) * MULQ_W'(DIV25_MUL);
      ylow1  <= year[1:0];
      moff1  <= month_offset(month);
      month1 <= month;
      day1   <= day;
      sod1   <= sod_c;
      fok1   <= fok_c;
    end
  end

  // Stage 2 logic.
  localparam int Q_W = MULQ_W - DIV25_SHIFT;
  logic [Q_W-1:0]    b_c;
  logic [Q_W-1:0]    qc_c;
  logic [QY_W-1:0]   r25_c;
  logic              leap_c;
  logic [DAY_W-1:0]  mlen_c;
  logic              dok_c;
  logic [SUM_W-1:0]  sum_c;

  // Leap year test and the day count with the 400-year correction terms.
  always_comb begin
    b_c    = amul1[MULQ_W-1:DIV25_SHIFT];       // yy / 100
    qc_c   = cmul1[MULQ_W-1:DIV25_SHIFT];       // year / 100
    r25_c  = c1 - (QY_W'(qc_c) * QY_W'(25));    // (year / 4) mod 25
    leap_c = (ylow1 == 2'd0) && ((r25_c != '0) || (qc_c[1:0] == 2'd0));
    mlen_c = month_length(month1, leap_c);
    dok_c  = (day1 != '0) && (day1 <= mlen_c);
    sum_c  = SUM_W'(yy1) * SUM_W'(DAYS_PER_YEAR) + SUM_W'(yy1[YEAR_W-1:2]) - SUM_W'(b_c)
           + SUM_W'(b_c[Q_W-1:2]) + SUM_W'(moff1) + SUM_W'(day1) - SUM_W'(1)
           - SUM_W'(EPOCH_SHIFT);
  end

  // Stage 2 register.
  always_ff @(posedge clk) begin
    if (ctrl.load2) begin
      days <= sum_c[DAYS_W-1:0];
      sod  <= sod1;
      ok   <= fok1 && dok_c;
    end
  end

endmodule

### hw/rtl/civil_date_to_epoch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// civil_date_to_epoch
// Converts a UTC calendar date and time into 32-bit Unix epoch seconds.
// ----------------------------------------------------------------------------
// Four register stages lie between the date transfer and the result
// (checks, day count, multiply by 86400, add and range check).
// Throughput: one date per cycle while results are taken; a stall on the
// result side holds every full stage in place and lets empty stages refill.
// Reset clears the stage valid bits only; the data registers are not reset.
module civil_date_to_epoch (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          date_valid,
  output logic                          date_ready,
  input  logic [cde_pkg::YEAR_W-1:0]    year,
  input  logic [cde_pkg::MONTH_W-1:0]   month,
  input  logic [cde_pkg::DAY_W-1:0]     day,
  input  logic [cde_pkg::HOUR_W-1:0]    hour,
  input  logic [cde_pkg::MINUTE_W-1:0]  minute,
  input  logic [cde_pkg::SECOND_W-1:0]  second,
  output logic                          epoch_valid,
  input  logic                          epoch_ready,
  output logic [cde_pkg::EPOCH_W-1:0]   epoch,
  output logic                          valid_res
);
  import cde_pkg::*;

  // Stage valid bits; stage 4 is the output register.
  logic v1, v2, v3;
  logic load1, load2, load3, load4;
  cde_ctrl_t ctrl;

  // A stage loads when it is empty or its contents move on.
  always_comb begin
    load4      = !epoch_valid || epoch_ready;
    load3      = !v3 || load4;
    load2      = !v2 || load3;
    load1      = !v1 || load2;
    date_ready = load1;
    ctrl.load1 = load1;
    ctrl.load2 = load2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      epoch_valid <= 1'b0;
    end else begin
      if (load1) v1 <= date_valid;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
      if (load4) epoch_valid <= v3;
    end
  end

  // Stages 1 and 2: checks and day count.
  logic [DAYS_W-1:0] days2;
  logic [SOD_W-1:0]  sod2;
  logic              ok2;

  cde_days u_days (
    .clk    (clk),
    .ctrl   (ctrl),
    .year   (year),
    .month  (month),
    .day    (day),
    .hour   (hour),
    .minute (minute),
    .second (second),
    .days   (days2),
    .sod    (sod2),
    .ok     (ok2)
  );

  // Stage 3: whole days into seconds.
  logic [SECS_W-1:0] prod3;
  logic [SOD_W-1:0]  sod3;
  logic              ok3;

  always_ff @(posedge clk) begin
    if (load3) begin
      prod3 <= SECS_W'(days2) * SECS_W'(SECS_PER_DAY);
      sod3  <= sod2;
      ok3   <= ok2;
    end
  end

  // Stage 4: add the time of day and reject zero or a count beyond 32 bits.
  logic [SECS_W-1:0] total_c;
  logic              ok_c;

  always_comb begin
    total_c = prod3 + SECS_W'(sod3);
    ok_c    = ok3 && (total_c != '0) && (total_c[SECS_W-1:EPOCH_W] == '0);
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      epoch     <= ok_c ? total_c[EPOCH_W-1:0] : '0;
      valid_res <= ok_c;
    end
  end

endmodule

### hw/rtl/cde_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cde_checker
// Port-level checks of the civil date to epoch converter, bound to the top.
// ----------------------------------------------------------------------------
module cde_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          date_valid,
  input  logic                          date_ready,
  input  logic [cde_pkg::YEAR_W-1:0]    year,
  input  logic [cde_pkg::MONTH_W-1:0]   month,
  input  logic [cde_pkg::DAY_W-1:0]     day,
  input  logic [cde_pkg::HOUR_W-1:0]    hour,
  input  logic [cde_pkg::MINUTE_W-1:0]  minute,
  input  logic [cde_pkg::SECOND_W-1:0]  second,
  input  logic                          epoch_valid,
  input  logic                          epoch_ready,
  input  logic [cde_pkg::EPOCH_W-1:0]   epoch,
  input  logic                          valid_res
);
  import cde_pkg::*;

  // A good result is never zero.
  a_good_nonzero: assert property (@(posedge clk) disable iff (rst)
    (epoch_valid && valid_res) |-> (epoch != '0))
    else $error("good result carries a zero epoch");

  // A rejected result carries a zero epoch.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (epoch_valid && !valid_res) |-> (epoch == '0))
    else $error("rejected result carries a nonzero epoch");

  // A stalled result holds until its transfer.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (epoch_valid && !epoch_ready) |=> (epoch_valid && $stable(epoch) && $stable(valid_res)))
    else $error("stalled result changed");

  // The pipeline is empty after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !epoch_valid)
    else $error("result valid right after reset");

  // A waiting date transfer keeps its valid and its fields until accepted.
  a_date_hold: assert property (@(posedge clk) disable iff (rst)
    (date_valid && !date_ready) |=>
    (date_valid && $stable({year, month, day, hour, minute, second})))
    else $error("waiting date changed before its transfer");

endmodule

bind civil_date_to_epoch cde_checker u_cde_checker (.*);

### verif/tb_civil_date_to_epoch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_civil_date_to_epoch
// Self-checking bench for the civil date to epoch converter. A table of
// directed dates covers field extremes, every rejection rule, leap Februaries
// and both ends of the 32-bit range. Constrained-by-hand random dates follow,
// mostly well-formed with some broken fields and some pure noise. Each result
// is checked against its expected value from the table or from a behavioral
// model of the day count, while the sender bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_civil_date_to_epoch;
  import cde_pkg::*;

  localparam int unsigned ERA_LEN_DAYS   = 146097;
  localparam int unsigned DAY0_SHIFT     = 719468;
  localparam int          RANDOM_DATES   = 500;
  localparam int          MAX_REPORTS    = 10;
  localparam int          DRAIN_CYCLES   = 12;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } date_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] secs;
    logic               ok;
  } epoch_result_t;

  typedef struct packed {
    date_t         date;
    logic          typed;
    epoch_result_t result;
  } date_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCK} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic date_valid = 1'b0;
  logic date_ready;
  logic [YEAR_W-1:0]   year = '0;
  logic [MONTH_W-1:0]  month = '0;
  logic [DAY_W-1:0]    day = '0;
  logic [HOUR_W-1:0]   hour = '0;
  logic [MINUTE_W-1:0] minute = '0;
  logic [SECOND_W-1:0] second = '0;
  logic epoch_valid;
  logic epoch_ready = 1'b0;
  logic [EPOCH_W-1:0] epoch;
  logic valid_res;

  epoch_result_t pending_epochs[$];
  date_row_t     date_table[$];
  int            mismatch_count = 0;
  rx_mode_t      rx_mode = RX_OPEN;
  int            rx_count = 0;

  civil_date_to_epoch u_dut (
    .clk         (clk),
    .rst         (rst),
    .date_valid  (date_valid),
    .date_ready  (date_ready),
    .year        (year),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .epoch_valid (epoch_valid),
    .epoch_ready (epoch_ready),
    .epoch       (epoch),
    .valid_res   (valid_res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gregorian month length, zero for a month number outside 1 to 12.
  function automatic int unsigned days_of_month(int unsigned y, int unsigned m);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    logic leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    if (m < 1 || m > 12) return 0;
    if (m == 2 && leap) return 29;
    return lens[m - 1];
  endfunction

  // Seconds since 1970-01-01 by the era-based day count, with every rejection.
  function automatic epoch_result_t date_to_epoch_secs(date_t d);
    logic [63:0] yy, era, yoe, mp, doy, doe, days, secs;
    epoch_result_t r;
    r = '0;
    if (d.year < YEAR_MIN || d.month < 1 || d.month > 12 || d.hour > 23 ||
        d.minute > 59 || d.second > 59) return r;
    if (d.day < 1 || d.day > days_of_month(d.year, d.month)) return r;
    // The year is taken to start in March so that leap days fall at its end.
    yy   = (d.month <= 2) ? 64'(d.year) - 1 : 64'(d.year);
    era  = yy / 400;
    yoe  = yy - era * 400;
    mp   = (d.month > 2) ? 64'(d.month) - 3 : 64'(d.month) + 9;
    doy  = (153 * mp + 2) / 5 + 64'(d.day) - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * ERA_LEN_DAYS + doe - DAY0_SHIFT;
    secs = days * SECS_PER_DAY + 64'(d.hour) * SECS_PER_HOUR +
           64'(d.minute) * SECS_PER_MIN + 64'(d.second);
    if (secs == 0 || secs > 64'hFFFF_FFFF) return r;
    r.secs = secs[EPOCH_W-1:0];
    r.ok   = 1'b1;
    return r;
  endfunction

  function automatic date_row_t mk_row(int unsigned y, int unsigned mo, int unsigned d,
                                       int unsigned h, int unsigned mi, int unsigned s,
                                       logic typed, logic [31:0] secs, logic ok);
    date_row_t r;
    r.date        = '{YEAR_W'(y), MONTH_W'(mo), DAY_W'(d), HOUR_W'(h), MINUTE_W'(mi),
                      SECOND_W'(s)};
    r.typed       = typed;
    r.result.secs = secs;
    r.result.ok   = ok;
    return r;
  endfunction

  // Random dates: mostly well-formed, some with one broken field, some noise.
  function automatic date_t random_date();
    date_t d;
    int unsigned pick;
    int unsigned y;
    pick = $urandom_range(99);
    if (pick < 10) begin
      d = date_t'({$urandom, $urandom});
      return d;
    end
    case ($urandom_range(9))
      0:       y = $urandom_range(1971, 1970);
      1, 2:    y = $urandom_range(2106, 2100);
      3:       y = $urandom_range(4095, 2107);
      default: y = $urandom_range(2106, 1970);
    endcase
    d.year   = YEAR_W'(y);
    d.month  = MONTH_W'($urandom_range(12, 1));
    d.day    = DAY_W'($urandom_range(days_of_month(y, d.month), 1));
    d.hour   = HOUR_W'($urandom_range(23));
    d.minute = MINUTE_W'($urandom_range(59));
    d.second = SECOND_W'($urandom_range(59));
    if (pick < 25) begin
      case ($urandom_range(6))
        0:       d.year   = YEAR_W'($urandom_range(1969));
        1:       d.month  = ($urandom_range(1) != 0) ? 4'd0 : 4'($urandom_range(15, 13));
        2:       d.day    = 5'($urandom_range(31, days_of_month(y, d.month) + 1));
        3:       d.day    = 5'd0;
        4:       d.hour   = HOUR_W'($urandom_range(31, 24));
        5:       d.minute = MINUTE_W'($urandom_range(63, 60));
        default: d.second = SECOND_W'($urandom_range(63, 60));
      endcase
    end
    return d;
  endfunction

  // Receiver: stall pattern is picked at random from four modes; results are checked here.
  always @(posedge clk) begin
    epoch_result_t want;
    if (rst) begin
      epoch_ready <= 1'b0;
    end else begin
      rx_count <= rx_count + 1;
      if (rx_count % 64 == 63) rx_mode <= rx_mode_t'($urandom_range(3));
      case (rx_mode)
        RX_OPEN:   epoch_ready <= 1'b1;
        RX_COIN:   epoch_ready <= 1'($urandom_range(1));
        RX_SPARSE: epoch_ready <= (rx_count % 4 == 0);
        RX_BLOCK:  epoch_ready <= (rx_count % 32 >= 12);
        default:   epoch_ready <= 1'b1;
      endcase
      if (epoch_valid && epoch_ready) begin
        if (pending_epochs.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < MAX_REPORTS)
            $display("ERROR: unexpected result transfer epoch=%0d valid_res=%0b",
                     epoch, valid_res);
        end else begin
          want = pending_epochs.pop_front();
          if (epoch !== want.secs || valid_res !== want.ok) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < MAX_REPORTS)
              $display("ERROR: epoch expected %0d/%0b, got %0d/%0b",
                       want.secs, want.ok, epoch, valid_res);
          end
        end
      end
    end
  end

  // Sender: directed table first, then random dates, in bursts with gaps.
  initial begin
    date_row_t row;
    int burst_left;
    int total;
    int gap;

    date_table.push_back(mk_row(1970, 1, 1, 0, 0, 0, 1, 0, 0));
    date_table.push_back(mk_row(1970, 1, 1, 0, 0, 1, 1, 1, 1));
    date_table.push_back(mk_row(1969, 12, 31, 23, 59, 59, 1, 0, 0));
    date_table.push_back(mk_row(0, 0, 0, 0, 0, 0, 1, 0, 0));
    date_table.push_back(mk_row(4095, 15, 31, 31, 63, 63, 1, 0, 0));
    date_table.push_back(mk_row(2000, 0, 10, 1, 2, 3, 1, 0, 0));
    date_table.push_back(mk_row(2000, 13, 10, 1, 2, 3, 1, 0, 0));
    date_table.push_back(mk_row(2000, 5, 0, 1, 2, 3, 1, 0, 0));
    date_table.push_back(mk_row(2021, 4, 31, 12, 0, 0, 1, 0, 0));
    date_table.push_back(mk_row(2000, 1, 1, 0, 0, 0, 1, 946684800, 1));
    date_table.push_back(mk_row(2000, 2, 29, 12, 30, 45, 0, 0, 0));
    date_table.push_back(mk_row(2100, 2, 29, 0, 0, 0, 1, 0, 0));
    date_table.push_back(mk_row(2024, 2, 29, 23, 59, 59, 0, 0, 0));
    date_table.push_back(mk_row(2023, 2, 29, 0, 0, 0, 1, 0, 0));
    date_table.push_back(mk_row(2023, 2, 28, 7, 8, 9, 0, 0, 0));
    date_table.push_back(mk_row(2010, 6, 15, 24, 0, 0, 1, 0, 0));
    date_table.push_back(mk_row(2010, 6, 15, 0, 60, 0, 1, 0, 0));
    date_table.push_back(mk_row(2010, 6, 15, 0, 0, 60, 1, 0, 0));
    date_table.push_back(mk_row(2038, 1, 19, 3, 14, 7, 1, 32'h7FFF_FFFF, 1));
    date_table.push_back(mk_row(2106, 2, 7, 6, 28, 15, 1, 32'hFFFF_FFFF, 1));
    date_table.push_back(mk_row(2106, 2, 7, 6, 28, 16, 1, 0, 0));
    date_table.push_back(mk_row(2106, 12, 31, 23, 59, 59, 1, 0, 0));
    date_table.push_back(mk_row(1970, 12, 31, 23, 59, 59, 0, 0, 0));
    date_table.push_back(mk_row(2023, 12, 31, 16, 31, 17, 0, 0, 0));
    date_table.push_back(mk_row(4095, 12, 31, 23, 59, 59, 1, 0, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    burst_left = 0;
    total = date_table.size() + RANDOM_DATES;
    for (int i = 0; i < total; i++) begin
      if (i < date_table.size()) begin
        row = date_table[i];
      end else begin
        row       = '0;
        row.date  = random_date();
      end
      if (!row.typed) row.result = date_to_epoch_secs(row.date);

      // Between bursts the sender may go quiet for a random stretch.
      if (burst_left == 0) begin
        burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        gap = $urandom_range(6);
        if (gap != 0) begin
          date_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;

      date_valid <= 1'b1;
      year       <= row.date.year;
      month      <= row.date.month;
      day        <= row.date.day;
      hour       <= row.date.hour;
      minute     <= row.date.minute;
      second     <= row.date.second;
      @(posedge clk);
      while (!date_ready) @(posedge clk);
      pending_epochs.push_back(row.result);
    end
    date_valid <= 1'b0;

    while (pending_epochs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
